[rtl/core/assert_macros.svh]
// assertion macros shared by the lot matching rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define LMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmp assertion failed");

// implication checked in the next cycle
`define LMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmp assertion failed");

`endif

[rtl/core/lmp_pkg.sv]
// types, constants and helpers of the lot matching pnl block
package lmp_pkg;

    localparam int LOT_DEPTH = 64;
    localparam int LOT_AW    = $clog2(LOT_DEPTH);
    localparam int LOT_CW    = $clog2(LOT_DEPTH + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] RESET_PRICE = 32'd1000000;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_FILL   = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // signed quantity, enough for -65535 .. 65535
    typedef logic signed [16:0] t_qty_s;

    typedef struct packed {
        logic        is_fill;
        logic [31:0] price;
        t_qty_s      delta;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [LOT_CW-1:0] lot_count;
        logic              busy;
    } t_bk_stat;

    function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
        logic signed [63:0] res;
        if (v[64] != v[63]) begin
            res = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            res = v[63:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/lmp_if.sv]
// valid/ready channel interfaces for items and results
interface lmp_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] price;
    logic        side;
    logic [15:0] quantity;

    modport source (output valid, operation, price, side, quantity, input ready);
    modport sink   (input valid, operation, price, side, quantity, output ready);
endinterface

interface lmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [63:0] realized_pnl;
    logic signed [63:0] unrealized_pnl;
    logic               status;

    modport source (output valid, position, realized_pnl, unrealized_pnl, status,
                    input ready);
    modport sink   (input valid, position, realized_pnl, unrealized_pnl, status,
                    output ready);
endinterface

[rtl/core/fifo_lot_matching_pnl.sv]
// top level of the fifo lot matching position and pnl tracker
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    operation, price, side, quantity
//  o_out    out  valid/ready    position, realized_pnl, unrealized_pnl, status
//
// back sequencer steps: tick umul, usub; fill check, then match, mulr, mulc, upd per
// matched lot (one more match if the head lot has the same sign), append, addc, umul,
// usub; each step holds at most one multiply of up to 32x33 bits, which sets the pace
// the front register and a 2-entry queue let new items arrive while a fill runs
// reset (i_rst_n low, synchronous) empties the lot store and sets last price to 1000000
// a result that is not taken holds the back stage in its final step
`include "assert_macros.svh"

module fifo_lot_matching_pnl (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lmp_in_if.sink    i_in,
    lmp_out_if.source o_out
);
    import lmp_pkg::*;

    logic     f_valid;
    t_cmd     f_cmd;
    logic     q_push;
    logic     q_valid;
    t_cmd     q_data;
    logic     q_pop;
    t_q_stat  q_stat;
    t_bk_stat bk_stat;

    assign q_push = f_valid && !q_stat.full;

    lmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_cmd   (f_cmd),
        .i_ready (!q_stat.full)
    );

    lmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    lmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_data),
        .o_pop   (q_pop),
        .o_out   (o_out),
        .o_stat  (bk_stat)
    );

    `LMP_ASSERT_IMP(a_lot_count_range, 1'b1, bk_stat.lot_count <= LOT_CW'(LOT_DEPTH))
    `LMP_ASSERT_IMP(a_flat_no_unrl, o_out.valid && o_out.position == 32'sd0, o_out.unrealized_pnl == 64'sd0)
    `LMP_ASSERT_NXT(a_push_fills_queue, q_push && q_stat.empty, !q_stat.empty)
    `LMP_ASSERT_NXT(a_front_holds, f_valid && q_stat.full, f_valid)
endmodule

[rtl/core/lmp_front.sv]
// front stage: takes input transfers and turns them into signed commands
module lmp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lmp_in_if.sink        i_in,
    output logic          o_valid,
    output lmp_pkg::t_cmd o_cmd,
    input  logic          i_ready
);
    import lmp_pkg::*;

    logic   r_valid;
    t_cmd   r_cmd;
    t_qty_s w_mag;
    logic   w_take;

    assign i_in.ready = !r_valid || i_ready;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_mag      = t_qty_s'({1'b0, i_in.quantity});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.is_fill <= (i_in.operation == OP_FILL);
            r_cmd.price   <= i_in.price;
            r_cmd.delta   <= (i_in.side == SIDE_SELL) ? -w_mag : w_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
endmodule

[rtl/core/lmp_queue.sv]
// short command queue between the front and back stages
module lmp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lmp_pkg::t_cmd    i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output lmp_pkg::t_cmd    o_data,
    output lmp_pkg::t_q_stat o_stat
);
    import lmp_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_valid      = !o_stat.empty;
    assign o_data       = r_mem[r_rp];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

[rtl/core/lmp_back.sv]
// back stage: fifo lot matching sequencer, lot memory and result register
module lmp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lmp_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    lmp_out_if.source         o_out,
    output lmp_pkg::t_bk_stat o_stat
);
    import lmp_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_CHECK  = 10'b0000000010,
        ST_MATCH  = 10'b0000000100,
        ST_MULR   = 10'b0000001000,
        ST_MULC   = 10'b0000010000,
        ST_UPD    = 10'b0000100000,
        ST_APPEND = 10'b0001000000,
        ST_ADDC   = 10'b0010000000,
        ST_UMUL   = 10'b0100000000,
        ST_USUB   = 10'b1000000000
    } t_state;

    t_state              r_state;
    logic [31:0]         r_price;
    t_qty_s              r_rem;
    t_qty_s              r_delta;
    logic                r_status;
    logic [LOT_AW-1:0]   r_head;
    logic [LOT_CW-1:0]   r_count;
    logic signed [31:0]  r_pos;
    logic signed [63:0]  r_real;
    logic signed [63:0]  r_cost;
    logic [31:0]         r_last;
    logic [15:0]         r_matched;
    logic [15:0]         r_mag;
    logic signed [32:0]  r_diff;
    logic [31:0]         r_lprice;
    logic                r_lneg;
    logic signed [63:0]  r_prod;

    // lot store
    t_qty_s              mem_size  [LOT_DEPTH];
    logic [31:0]         mem_price [LOT_DEPTH];
    t_qty_s              r_rd_size;
    logic [31:0]         r_rd_price;

    logic                r_out_valid;
    logic signed [31:0]  r_o_pos;
    logic signed [63:0]  r_o_real;
    logic signed [63:0]  r_o_unrl;
    logic                r_o_status;

    logic                w_take;
    logic                w_out_free;
    logic [LOT_AW:0]     w_tsum;
    logic [LOT_AW-1:0]   w_tail;
    logic [LOT_AW-1:0]   w_head_nx;
    logic                w_opp;
    logic [15:0]         w_lmag;
    logic [15:0]         w_rmag;
    logic signed [49:0]  w_mulr;
    logic [47:0]         w_mulc;
    logic signed [49:0]  w_mula;
    logic signed [64:0]  w_mulu;
    logic signed [63:0]  w_radd;
    logic [15:0]         w_newmag;
    logic                w_we_size;
    logic                w_we_price;
    logic [LOT_AW-1:0]   w_waddr;
    t_qty_s              w_wsize;
    logic                w_store_ok;

    assign o_pop      = (r_state == ST_IDLE);
    assign w_take     = i_valid && o_pop;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_tsum    = (LOT_AW + 1)'(r_head) + (LOT_AW + 1)'(r_count);
    assign w_tail    = (w_tsum >= (LOT_AW + 1)'(LOT_DEPTH)) ?
                       LOT_AW'(w_tsum - (LOT_AW + 1)'(LOT_DEPTH)) : w_tsum[LOT_AW-1:0];
    assign w_head_nx = (r_head == LOT_AW'(LOT_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // head lot must be nonzero and of the opposite sign to the remainder
    assign w_opp  = (r_rd_size != '0) && (r_rd_size[16] != r_rem[16]);
    assign w_lmag = r_rd_size[16] ? 16'(-r_rd_size) : r_rd_size[15:0];
    assign w_rmag = r_rem[16] ? 16'(-r_rem) : r_rem[15:0];

    assign w_mulr   = $signed({1'b0, r_matched}) * r_diff;
    assign w_mulc   = r_matched * r_lprice;
    assign w_mula   = r_rem * $signed({1'b0, r_price});
    assign w_mulu   = r_pos * $signed({1'b0, r_last});
    assign w_radd   = r_lneg ? -r_prod : r_prod;
    assign w_newmag = r_mag - r_matched;

    assign w_store_ok = (r_count != LOT_CW'(LOT_DEPTH));
    assign w_we_size  = (r_state == ST_UPD) ||
                        ((r_state == ST_APPEND) && (r_rem != '0) && w_store_ok);
    assign w_we_price = (r_state == ST_APPEND) && (r_rem != '0) && w_store_ok;
    assign w_waddr    = (r_state == ST_UPD) ? r_head : w_tail;
    assign w_wsize    = (r_state == ST_UPD) ?
                        (r_lneg ? -t_qty_s'({1'b0, w_newmag}) : t_qty_s'({1'b0, w_newmag}))
                        : r_rem;

    always_ff @(posedge i_clk) begin
        if (w_we_size) begin
            mem_size[w_waddr] <= w_wsize;
        end
        if (w_we_price) begin
            mem_price[w_waddr] <= r_price;
        end
        r_rd_size  <= mem_size[r_head];
        r_rd_price <= mem_price[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_real      <= '0;
            r_cost      <= '0;
            r_last      <= RESET_PRICE;
            r_out_valid <= 1'b0;
        end else begin
            // the final step loads the next result itself
            if (r_out_valid && o_out.ready && (r_state != ST_USUB)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_price  <= i_cmd.price;
                        r_delta  <= i_cmd.delta;
                        r_rem    <= i_cmd.is_fill ? i_cmd.delta : '0;
                        r_status <= STAT_OK;
                        if (i_cmd.is_fill) begin
                            r_state <= ST_CHECK;
                        end else begin
                            r_last  <= i_cmd.price;
                            r_state <= ST_UMUL;
                        end
                    end
                end
                ST_CHECK: begin
                    // read of the head lot is in flight this cycle
                    r_state <= (r_count != '0 && r_rem != '0) ? ST_MATCH : ST_APPEND;
                end
                ST_MATCH: begin
                    if (w_opp) begin
                        r_lneg    <= r_rd_size[16];
                        r_mag     <= w_lmag;
                        r_matched <= (w_rmag < w_lmag) ? w_rmag : w_lmag;
                        r_diff    <= $signed({1'b0, r_price}) - $signed({1'b0, r_rd_price});
                        r_lprice  <= r_rd_price;
                        r_state   <= ST_MULR;
                    end else begin
                        r_state <= ST_APPEND;
                    end
                end
                ST_MULR: begin
                    r_prod  <= 64'(w_mulr);
                    r_state <= ST_MULC;
                end
                ST_MULC: begin
                    r_real  <= sat64({r_real[63], r_real} + {w_radd[63], w_radd});
                    r_prod  <= $signed({16'd0, w_mulc});
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_cost <= r_lneg ? r_cost + r_prod : r_cost - r_prod;
                    r_rem  <= r_rem[16] ? r_rem + t_qty_s'({1'b0, r_matched})
                                        : r_rem - t_qty_s'({1'b0, r_matched});
                    if (w_newmag == '0) begin
                        r_head  <= w_head_nx;
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= ST_CHECK;
                end
                ST_APPEND: begin
                    r_prod <= ((r_rem != '0) && w_store_ok) ? 64'(w_mula) : '0;
                    if (r_rem != '0) begin
                        if (w_store_ok) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_status <= STAT_FULL;
                        end
                    end
                    r_pos   <= sat32({r_pos[31], r_pos} + 33'(r_delta));
                    r_state <= ST_ADDC;
                end
                ST_ADDC: begin
                    r_cost  <= r_cost + r_prod;
                    r_state <= ST_UMUL;
                end
                ST_UMUL: begin
                    // |position| <= 2^31 and price < 2^32, product fits 64 bits
                    r_prod  <= w_mulu[63:0];
                    r_state <= ST_USUB;
                end
                ST_USUB: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_pos     <= r_pos;
                        r_o_real    <= r_real;
                        r_o_status  <= r_status;
                        if (r_pos == '0 || r_count == '0) begin
                            r_o_unrl <= '0;
                        end else begin
                            r_o_unrl <= sat64({r_prod[63], r_prod} - {r_cost[63], r_cost});
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.position       = r_o_pos;
    assign o_out.realized_pnl   = r_o_real;
    assign o_out.unrealized_pnl = r_o_unrl;
    assign o_out.status         = r_o_status;

    assign o_stat.lot_count = r_count;
    assign o_stat.busy      = (r_state != ST_IDLE);
endmodule

[tb/fifo_lot_matching_pnl_checker.sv]
// lot matching pnl checker: predicts each result from the accepted items and compares
`timescale 1ns / 100ps

module fifo_lot_matching_pnl_checker
    import lmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lmp_in_if    i_in,
    lmp_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic signed [31:0] position;
        logic signed [63:0] realized_pnl;
        logic signed [63:0] unrealized_pnl;
        logic               status;
    } t_pnl_result;

    localparam logic signed [63:0] PNL_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] PNL_MIN = {1'b1, 63'd0};

    t_pnl_result        results_due[$];
    logic signed [31:0] book_size[LOT_DEPTH];
    logic [31:0]        book_price[LOT_DEPTH];
    int                 book_head;
    int                 book_count;
    logic signed [31:0] net_pos;
    logic signed [63:0] realized_sum;
    logic signed [63:0] open_cost;
    logic [31:0]        mark_price;

    function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input logic subtract);
        logic signed [64:0] s;
        s = subtract ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return s[64] ? PNL_MIN : PNL_MAX;
        end
        return s[63:0];
    endfunction

    // walks the lot book for one transfer and returns the expected result
    function automatic t_pnl_result book_update(input logic op, input logic [31:0] px,
                                                input logic sd, input logic [15:0] qty);
        t_pnl_result r;
        longint rem, sz, lsign, mag, rmag, matched, diff, newpos;
        int tail;
        r.status = STAT_OK;
        if (op == OP_FILL) begin
            rem = (sd == SIDE_SELL) ? -longint'(qty) : longint'(qty);
            while (book_count > 0 && rem != 0) begin
                sz = longint'(book_size[book_head]);
                if (!((rem > 0 && sz < 0) || (rem < 0 && sz > 0))) break;
                lsign = sz > 0 ? 1 : -1;
                mag = sz * lsign;
                rmag = rem < 0 ? -rem : rem;
                matched = rmag < mag ? rmag : mag;
                diff = longint'(px) - longint'(book_price[book_head]);
                realized_sum = clamp_sum(realized_sum, matched * diff * lsign, 1'b0);
                open_cost = open_cost - matched * lsign * longint'(book_price[book_head]);
                sz = sz - matched * lsign;
                book_size[book_head] = sz[31:0];
                rem = rem > 0 ? rem - matched : rem + matched;
                if (sz == 0) begin
                    book_head = (book_head + 1) % LOT_DEPTH;
                    book_count--;
                end
            end
            if (rem != 0) begin
                if (book_count < LOT_DEPTH) begin
                    tail = (book_head + book_count) % LOT_DEPTH;
                    book_size[tail] = rem[31:0];
                    book_price[tail] = px;
                    book_count++;
                    open_cost = open_cost + rem * longint'(px);
                end else begin
                    r.status = STAT_FULL;
                end
            end
            newpos = longint'(net_pos) + ((sd == SIDE_SELL) ? -longint'(qty) : longint'(qty));
            if (newpos > 64'sd2147483647) newpos = 64'sd2147483647;
            if (newpos < -64'sd2147483648) newpos = -64'sd2147483648;
            net_pos = newpos[31:0];
        end else begin
            mark_price = px;
        end
        r.position = net_pos;
        r.realized_pnl = realized_sum;
        if (net_pos == 0 || book_count == 0) begin
            r.unrealized_pnl = 0;
        end else begin
            r.unrealized_pnl = clamp_sum(longint'(net_pos) * longint'({32'd0, mark_price}),
                                         open_cost, 1'b1);
        end
        return r;
    endfunction

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        t_pnl_result want;
        if (!i_rst_n) begin
            results_due.delete();
            book_head <= 0;
            book_count <= 0;
            net_pos <= '0;
            realized_sum <= '0;
            open_cost <= '0;
            mark_price <= RESET_PRICE;
            o_fail_count <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transfer with none expected", $time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    if (want.position !== i_out.position ||
                        want.realized_pnl !== i_out.realized_pnl ||
                        want.unrealized_pnl !== i_out.unrealized_pnl ||
                        want.status !== i_out.status) begin
                        $display("%0t: mismatch expected pos %0d real %0d unreal %0d st %0b",
                                 $time, want.position, want.realized_pnl,
                                 want.unrealized_pnl, want.status);
                        $display("%0t:          actual   pos %0d real %0d unreal %0d st %0b",
                                 $time, i_out.position, i_out.realized_pnl,
                                 i_out.unrealized_pnl, i_out.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                // state updated in place, so blocking here keeps back-to-back items right
                results_due.insert(results_due.size(),
                                   book_update(i_in.operation, i_in.price,
                                               i_in.side, i_in.quantity));
            end
        end
    end

endmodule

[tb/fifo_lot_matching_pnl_test.sv]
// top of the lot matching pnl testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module fifo_lot_matching_pnl_test;
    import lmp_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 1050;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   items_sent;
    logic gaps_on;
    int   stall_left;

    lmp_in_if  in_ch ();
    lmp_out_if out_ch ();

    fifo_lot_matching_pnl dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    fifo_lot_matching_pnl_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (!gaps_on) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [31:0] px, input logic sd,
                             input logic [15:0] qty);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.price <= px;
        in_ch.side <= sd;
        in_ch.quantity <= qty;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_price();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return 32'd900000 + 32'($urandom_range(0, 200000));
        endcase
    endfunction

    function automatic logic [15:0] pick_qty();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 500));
        endcase
    endfunction

    initial begin
        int run_len;
        logic run_side;
        cycle_count = 0;
        items_sent = 0;
        stall_left = 0;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.price = '0;
        in_ch.side = SIDE_BUY;
        in_ch.quantity = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset price in use, extremes, zero quantity, crossing fills
        send_item(OP_FILL, 32'd1000000, SIDE_BUY, 16'd100);
        send_item(OP_FILL, 32'd1000500, SIDE_BUY, 16'd0);
        send_item(OP_TICK, 32'hFFFF_FFFF, SIDE_SELL, 16'hFFFF);
        send_item(OP_FILL, 32'hFFFF_FFFF, SIDE_BUY, 16'hFFFF);
        send_item(OP_FILL, 32'd0, SIDE_SELL, 16'hFFFF);
        send_item(OP_TICK, 32'd0, SIDE_BUY, 16'd0);
        send_item(OP_FILL, 32'd0, SIDE_SELL, 16'd300);
        send_item(OP_FILL, 32'hFFFF_FFFF, SIDE_BUY, 16'd1000);
        send_item(OP_FILL, 32'h5555_5555, SIDE_SELL, 16'h5555);
        send_item(OP_FILL, 32'hAAAA_AAAA, SIDE_BUY, 16'hAAAA);
        send_item(OP_TICK, 32'd1000000, SIDE_BUY, 16'd0);
        send_item(OP_FILL, 32'd1000000, SIDE_SELL, 16'd0);
        send_item(OP_FILL, 32'd999000, SIDE_SELL, 16'd1);
        send_item(OP_TICK, 32'h8000_0000, SIDE_SELL, 16'h8000);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 120) gaps_on = 1'b0;
            if (items_sent > 400 && items_sent < 420) begin
                // let the block drain completely
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(1'($urandom_range(0, 1)), pick_price(),
                                   1'($urandom_range(0, 1)), pick_qty());
                3, 4: send_item(OP_TICK, pick_price(), 1'($urandom_range(0, 1)),
                                16'($urandom_range(0, 65535)));
                5, 6, 7: begin
                    run_len = $urandom_range(1, 12);
                    run_side = 1'($urandom_range(0, 1));
                    repeat (run_len) send_item(OP_FILL, pick_price(), run_side, pick_qty());
                end
                default: begin
                    // long one-sided run can fill the lot book, then unwind it
                    run_side = 1'($urandom_range(0, 1));
                    repeat ($urandom_range(60, 72))
                        send_item(OP_FILL, pick_price(), run_side,
                                  16'($urandom_range(1, 400)));
                    repeat ($urandom_range(2, 8))
                        send_item(OP_FILL, pick_price(), ~run_side,
                                  16'($urandom_range(1, 65535)));
                end
            endcase
        end
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
